/* sv/rtsc_pkg.sv */
// Shared types and constants of the resistive touch scan controller.
package rtsc_pkg;

  // Width of the ADC sample field on the input channel.
  localparam int unsigned SampleW = 12;
  // Default number of low sample bits that the scan logic uses.
  localparam int unsigned SampleBitsDefault = 12;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTouchThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPenDownSkip    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainX          = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOffsetX        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGainY          = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOffsetY        = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [11:0]        ThresholdReset = 12'd100;
  localparam logic [7:0]         PenSkipReset   = 8'd6;
  localparam logic signed [23:0] GainReset      = 24'sd65536;
  localparam logic signed [31:0] OffsetReset    = 32'sd0;

  // Skip count after reset, and after an ordinary scan step.
  localparam logic [7:0] SkipAfterReset = 8'd10;
  localparam logic [7:0] SkipOne        = 8'd1;

  // Panel drive patterns: bit 0 is line A, bit 1 is line B.
  localparam logic [1:0] DriveIdle  = 2'd0;
  localparam logic [1:0] DriveReadY = 2'd1;
  localparam logic [1:0] DriveReadX = 2'd2;

  // ADC channel select codes.
  localparam logic ChanX = 1'b0;
  localparam logic ChanY = 1'b1;

  typedef enum logic [1:0] {
    EvNone = 2'd0,
    EvDown = 2'd1,
    EvMove = 2'd2,
    EvUp   = 2'd3
  } event_e;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    event_e             event_res;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         drive_lines;
    logic               channel_y;
  } result_t;

endpackage

/* sv/rtsc_stream_if.sv */
// Valid/ready channel interface that carries one payload per transaction.
interface rtsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/resistive_touch_scan_controller.sv */
// A result transaction is valid in the cycle after its sample transaction is accepted.
// Throughput: one sample per cycle while results are taken; a result not taken stalls input.
// The scan state and calibration are updated in a single pass between input and result register.
// Reset (asynchronous, active low) loads the default configuration, detect phase,
// a skip count of ten, pen up, zero position, idle drive lines and the Y channel.
module resistive_touch_scan_controller #(
  parameter int unsigned SAMPLE_BITS = rtsc_pkg::SampleBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtsc_pkg::CfgDataW-1:0] cfg_data_i,
  rtsc_stream_if.sink                   sample_if,
  rtsc_stream_if.source                 result_if
);

  // Only the low bits of the sample take part; the field itself is fixed in width.
  localparam int unsigned UseBits =
    (SAMPLE_BITS < rtsc_pkg::SampleW) ? SAMPLE_BITS : rtsc_pkg::SampleW;
  localparam int unsigned ProdW = rtsc_pkg::SampleW + 1 + 24;
  localparam int unsigned SumW  = ProdW + 1;

  typedef enum logic [1:0] {
    PhDetect = 2'd0,
    PhReadX  = 2'd1,
    PhReadY  = 2'd2
  } phase_e;

  // Calibrated position: raw * gain + offset in Q.16, truncated toward zero,
  // then saturated to the signed 16-bit pixel range.
  function automatic logic signed [15:0] calibrate(
    input logic [rtsc_pkg::SampleW-1:0] raw,
    input logic signed [23:0]           gain,
    input logic signed [31:0]           offset
  );
    logic signed [ProdW-1:0] prod;
    logic signed [SumW-1:0]  sum;
    logic signed [SumW-1:0]  adj;
    logic signed [SumW-17:0] whole;
    logic signed [15:0]      res;
    prod = $signed({1'b0, raw}) * gain;
    sum  = SumW'(prod) + SumW'(offset);
    // Adding 2^16 - 1 to a negative value turns the floor shift into truncation toward zero.
    adj   = sum + (sum[SumW-1] ? SumW'(65535) : SumW'(0));
    whole = adj[SumW-1:16];
    if (whole > (SumW-16)'(32767)) begin
      res = 16'sh7FFF;
    end else if (whole < -(SumW-16)'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = whole[15:0];
    end
    return res;
  endfunction

  // Configuration registers.
  logic [11:0]        threshold_q;
  logic [7:0]         pen_skip_q;
  logic signed [23:0] gain_x_q, gain_y_q;
  logic signed [31:0] offset_x_q, offset_y_q;

  // Scan state.
  phase_e             phase_q, phase_d;
  logic [7:0]         skip_q, skip_d;
  logic               pen_down_q, pen_down_d;
  logic [UseBits-1:0] raw_x_q, raw_x_d;
  logic signed [15:0] last_x_q, last_x_d;
  logic signed [15:0] last_y_q, last_y_d;
  logic [1:0]         drive_q, drive_d;
  logic               chan_q, chan_d;

  // Result register.
  logic               res_valid_q, res_valid_d;
  rtsc_pkg::result_t  res_q, res_d;

  logic               in_fire;
  logic [UseBits-1:0] smp;
  rtsc_pkg::event_e   ev;

  // A new sample is taken whenever the result register is empty or is being
  // emptied in this cycle, so only a waiting result that is not taken stalls the input side.
  assign sample_if.ready  = !res_valid_q || result_if.ready;
  assign in_fire          = sample_if.valid && sample_if.ready;
  assign smp              = sample_if.payload[UseBits-1:0];
  assign result_if.valid   = res_valid_q;
  assign result_if.payload = res_q;

  always_comb begin
    phase_d    = phase_q;
    skip_d     = skip_q;
    pen_down_d = pen_down_q;
    raw_x_d    = raw_x_q;
    last_x_d   = last_x_q;
    last_y_d   = last_y_q;
    drive_d    = drive_q;
    chan_d     = chan_q;
    ev         = rtsc_pkg::EvNone;

    if (skip_q != 8'd0) begin
      // Settling samples after a drive change are dropped.
      skip_d = skip_q - 8'd1;
    end else begin
      unique case (phase_q)
        PhReadX: begin
          raw_x_d = smp;
          phase_d = PhReadY;
          drive_d = rtsc_pkg::DriveReadY;
          chan_d  = rtsc_pkg::ChanY;
          skip_d  = rtsc_pkg::SkipOne;
        end
        PhReadY: begin
          last_x_d = calibrate(rtsc_pkg::SampleW'(raw_x_q), gain_x_q, offset_x_q);
          last_y_d = calibrate(rtsc_pkg::SampleW'(smp), gain_y_q, offset_y_q);
          phase_d  = PhDetect;
          drive_d  = rtsc_pkg::DriveIdle;
          chan_d   = rtsc_pkg::ChanX;
          if (!pen_down_q) begin
            pen_down_d = 1'b1;
            ev         = rtsc_pkg::EvDown;
            skip_d     = pen_skip_q;
          end else begin
            ev     = rtsc_pkg::EvMove;
            skip_d = rtsc_pkg::SkipOne;
          end
        end
        default: begin
          // Detect phase; the unused phase code behaves the same way.
          chan_d = rtsc_pkg::ChanX;
          if (rtsc_pkg::SampleW'(smp) > threshold_q) begin
            phase_d = PhReadX;
            drive_d = rtsc_pkg::DriveReadX;
          end else begin
            phase_d = PhDetect;
            drive_d = rtsc_pkg::DriveIdle;
            if (pen_down_q) begin
              pen_down_d = 1'b0;
              ev         = rtsc_pkg::EvUp;
            end
          end
          skip_d = rtsc_pkg::SkipOne;
        end
      endcase
    end

    res_d.event_res   = ev;
    res_d.pos_x       = last_x_d;
    res_d.pos_y       = last_y_d;
    res_d.drive_lines = drive_d;
    res_d.channel_y   = chan_d;

    if (in_fire) begin
      res_valid_d = 1'b1;
    end else if (result_if.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= rtsc_pkg::ThresholdReset;
      pen_skip_q  <= rtsc_pkg::PenSkipReset;
      gain_x_q    <= rtsc_pkg::GainReset;
      offset_x_q  <= rtsc_pkg::OffsetReset;
      gain_y_q    <= rtsc_pkg::GainReset;
      offset_y_q  <= rtsc_pkg::OffsetReset;
      phase_q     <= PhDetect;
      skip_q      <= rtsc_pkg::SkipAfterReset;
      pen_down_q  <= 1'b0;
      raw_x_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      drive_q     <= rtsc_pkg::DriveIdle;
      chan_q      <= rtsc_pkg::ChanY;
      res_valid_q <= 1'b0;
    end else begin
      // Writes to indexes beyond the register list are ignored.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rtsc_pkg::CfgTouchThreshold: threshold_q <= cfg_data_i[11:0];
          rtsc_pkg::CfgPenDownSkip:    pen_skip_q  <= cfg_data_i[7:0];
          rtsc_pkg::CfgGainX:          gain_x_q    <= cfg_data_i[23:0];
          rtsc_pkg::CfgOffsetX:        offset_x_q  <= cfg_data_i;
          rtsc_pkg::CfgGainY:          gain_y_q    <= cfg_data_i[23:0];
          rtsc_pkg::CfgOffsetY:        offset_y_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_q    <= phase_d;
        skip_q     <= skip_d;
        pen_down_q <= pen_down_d;
        raw_x_q    <= raw_x_d;
        last_x_q   <= last_x_d;
        last_y_q   <= last_y_d;
        drive_q    <= drive_d;
        chan_q     <= chan_d;
      end
      res_valid_q <= res_valid_d;
    end
  end

  // The payload register needs no reset; it is only read while valid.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // A Y sample that is not skipped always completes a pair and reports down or move.
  a_read_y_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && skip_q == 8'd0 && phase_q == PhReadY |=>
      res_valid_q && (res_q.event_res == rtsc_pkg::EvDown ||
                      res_q.event_res == rtsc_pkg::EvMove))
    else $error("read Y step did not report pen down or move");

  // The pen goes down only together with a pen-down transaction.
  a_pen_down_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pen_down_q) |-> res_valid_q && res_q.event_res == rtsc_pkg::EvDown)
    else $error("pen state set without a pen-down event");

  // A pen-up transaction leaves the panel undriven on the X channel.
  a_pen_up_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.event_res == rtsc_pkg::EvUp |->
      res_q.drive_lines == rtsc_pkg::DriveIdle && res_q.channel_y == rtsc_pkg::ChanX)
    else $error("pen up reported with the panel still driven");

endmodule
